// ===== src/evs_pkg.sv =====
// shared types and constants of the exponential variate sampler
`timescale 1ns / 1ps
package evs_pkg;
    localparam int UNI_BITS  = 32;
    localparam int E_W       = 6;
    localparam int M_W       = 64;
    localparam int FRAC_BITS = 56;
    localparam int T_W       = 63;
    localparam int L_W       = 62;
    localparam int RATE_W    = 32;
    localparam int OUT_W     = 32;
    localparam logic [63:0] LN2Q64 = 64'hB17217F7D1CF79AB;

    typedef struct packed {
        logic                 valid;
        logic [E_W-1:0]       e;
        logic [M_W-1:0]       m;
        logic [FRAC_BITS-1:0] f;
    } t_log_beat;

    typedef struct packed {
        logic              valid;
        logic [L_W-1:0]    dvd;
        logic [RATE_W-1:0] rem;
        logic [L_W-1:0]    quo;
    } t_div_beat;
endpackage

// ===== src/evs_log_cell.sv =====
// one log2 fraction bit: square the mantissa over two stages, then renormalize
`timescale 1ns / 1ps
module evs_log_cell import evs_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_en,
    input  t_log_beat i_beat,
    output t_log_beat o_beat
);
    logic                 r_a_valid;
    logic [E_W-1:0]       r_a_e;
    logic [FRAC_BITS-1:0] r_a_f;
    logic [63:0]          r_p00, r_p01, r_p11;
    logic [127:0]         w_sq;
    logic [M_W-1:0]       w_m;
    t_log_beat            r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_en) begin
            r_a_valid <= i_beat.valid;
        end
        if (i_en) begin
            r_a_e <= i_beat.e;
            r_a_f <= i_beat.f;
            r_p00 <= 64'(i_beat.m[31:0]) * 64'(i_beat.m[31:0]);
            r_p01 <= 64'(i_beat.m[31:0]) * 64'(i_beat.m[63:32]);
            r_p11 <= 64'(i_beat.m[63:32]) * 64'(i_beat.m[63:32]);
        end
    end

    assign w_sq = {r_p11, 64'd0} + {31'd0, r_p01, 33'd0} + {64'd0, r_p00};
    assign w_m  = w_sq[125:62];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_out.valid <= r_a_valid;
        end
        if (i_en) begin
            r_out.e <= r_a_e;
            r_out.f <= {r_a_f[FRAC_BITS-2:0], w_m[63]};
            r_out.m <= w_m[63] ? {1'b0, w_m[63:1]} : w_m;
        end
    end

    assign o_beat = r_out;
endmodule

// ===== src/evs_div_cell.sv =====
// one restoring division step: one quotient bit per cell
`timescale 1ns / 1ps
module evs_div_cell import evs_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [RATE_W-1:0] i_rate,
    input  t_div_beat         i_beat,
    output t_div_beat         o_beat
);
    logic [RATE_W:0] w_sh;
    logic [RATE_W:0] w_diff;
    logic            w_ge;
    t_div_beat       r_out;

    assign w_sh   = {i_beat.rem, i_beat.dvd[L_W-1]};
    assign w_diff = w_sh - {1'b0, i_rate};
    assign w_ge   = (w_sh >= {1'b0, i_rate});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (i_en) begin
            r_out.valid <= i_beat.valid;
        end
        if (i_en) begin
            r_out.dvd <= {i_beat.dvd[L_W-2:0], 1'b0};
            r_out.rem <= w_ge ? w_diff[RATE_W-1:0] : w_sh[RATE_W-1:0];
            r_out.quo <= {i_beat.quo[L_W-2:0], w_ge};
        end
    end

    assign o_beat = r_out;
endmodule

// ===== src/exponential_variate_sampler.sv =====
// top level: -ln(u)/rate through a log cell chain and a division cell chain
// beat path: s0, s1, log cells, t, ln2 products, division cells, output register
// throughput: one beat per cycle; the whole pipeline stalls while an output beat waits
// 56 log cells of two stages each and 62 division cells set the latency
// synchronous active-low reset clears all valid bits and sets rate to 1.0
`timescale 1ns / 1ps
module exponential_variate_sampler import evs_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [UNI_BITS-1:0] i_uniform_sample,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [OUT_W-1:0]    o_variate,
    output logic                o_saturated,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RATE_W-1:0]   i_cfg_rate
);
    logic                w_en;
    logic [RATE_W-1:0]   r_rate;
    logic                r_s0_valid;
    logic [UNI_BITS-1:0] r_s0_u;
    logic [E_W-1:0]      r_s0_e;
    logic [UNI_BITS-1:0] w_u;
    logic [E_W-1:0]      w_e;
    t_log_beat           w_log [0:FRAC_BITS];
    t_log_beat           r_s1;
    logic                r_t_valid;
    logic [T_W-1:0]      r_t;
    logic [T_W-1:0]      w_t;
    logic                r_p_valid;
    logic [63:0]         r_q00, r_q01, r_q10, r_q11;
    logic [127:0]        w_prod;
    t_div_beat           w_div [0:L_W];
    logic [L_W:0]        w_rnd;
    logic                w_ovf;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_variate;
    logic                r_sat;

    assign w_en        = !r_out_valid || i_ready;
    assign o_ready     = w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_W'(65536);
        end else if (i_cfg_valid) begin
            r_rate <= i_cfg_rate;
        end
    end

    // clamp and leading one
    always_comb begin
        w_u = (i_uniform_sample == '0) ? UNI_BITS'(1) : i_uniform_sample;
        w_e = '0;
        for (int i = 0; i < UNI_BITS; i++) begin
            if (w_u[i]) w_e = E_W'(i);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
            r_s1.valid <= 1'b0;
        end else if (w_en) begin
            r_s0_valid <= i_valid;
            r_s1.valid <= r_s0_valid;
        end
        if (w_en) begin
            r_s0_u <= w_u;
            r_s0_e <= w_e;
            r_s1.e <= r_s0_e;
            r_s1.m <= {{(M_W-UNI_BITS){1'b0}}, r_s0_u} << (E_W'(62) - r_s0_e);
            r_s1.f <= '0;
        end
    end

    assign w_log[0] = r_s1;

    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_log
        evs_log_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_beat (w_log[g]),
            .o_beat (w_log[g+1])
        );
    end

    assign w_t = {7'(UNI_BITS) - {1'b0, w_log[FRAC_BITS].e}, {FRAC_BITS{1'b0}}}
               - {{(T_W-FRAC_BITS){1'b0}}, w_log[FRAC_BITS].f};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else if (w_en) begin
            r_t_valid <= w_log[FRAC_BITS].valid;
            r_p_valid <= r_t_valid;
        end
        if (w_en) begin
            r_t   <= w_t;
            r_q00 <= 64'(r_t[31:0]) * 64'(LN2Q64[31:0]);
            r_q01 <= 64'(r_t[31:0]) * 64'(LN2Q64[63:32]);
            r_q10 <= 64'({1'b0, r_t[62:32]}) * 64'(LN2Q64[31:0]);
            r_q11 <= 64'({1'b0, r_t[62:32]}) * 64'(LN2Q64[63:32]);
        end
    end

    assign w_prod = {r_q11, 64'd0} + {32'd0, r_q01, 32'd0}
                  + {32'd0, r_q10, 32'd0} + {64'd0, r_q00};

    assign w_div[0].valid = r_p_valid;
    assign w_div[0].dvd   = w_prod[64+L_W-1:64];
    assign w_div[0].rem   = '0;
    assign w_div[0].quo   = '0;

    for (genvar g = 0; g < L_W; g++) begin : g_div
        evs_div_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (w_en),
            .i_rate (r_rate),
            .i_beat (w_div[g]),
            .o_beat (w_div[g+1])
        );
    end

    // round half up, saturate
    assign w_rnd = {1'b0, w_div[L_W].quo} + (L_W+1)'(1 << 23);
    assign w_ovf = (w_rnd[L_W:56] != '0) || (r_rate == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div[L_W].valid;
        end
        if (w_en) begin
            r_variate <= w_ovf ? '1 : w_rnd[55:24];
            r_sat     <= w_ovf;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_variate   = r_variate;
    assign o_saturated = r_sat;

`ifndef ASSERT_OFF
    a_sat_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturated |-> o_variate == '1)
        else $error("saturated beat without full-scale variate");

    a_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && r_rate == '0 |-> o_saturated)
        else $error("zero rate gave unsaturated beat");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat right after reset");
`endif
endmodule
